@@ rtl/sbom_pkg.sv @@
// Shared types and fixed field widths for the sparse band offset mapper.
// No dependencies; imported by sbom_table and sparse_band_offset_mapper_unit.
package sbom_pkg;

    localparam int ROW_W   = 17;
    localparam int LEFT_W  = 18;
    localparam int RIGHT_W = 17;
    localparam int CPC_W   = 4;
    localparam int OUT_W   = 32;
    localparam int DIFF_W  = 18;
    localparam int PROD_W  = DIFF_W + CPC_W;

    localparam logic [CPC_W-1:0] CPC_RESET = 4'd3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAP   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_MATCH = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEEK,
        S_CHECK,
        S_DONE
    } state_t;

    // Match request presented to the bound table while it scans.
    typedef struct packed {
        logic signed [ROW_W:0]    target_row;
        logic signed [LEFT_W-1:0] col;
        logic [CPC_W-1:0]         cpc;
    } probe_t;

endpackage

@@ rtl/sbom_table.sv @@
// Outer bound table: one synchronous memory with registered read, plus the
// match test and inner offset computation on the entry just read. Uses sbom_pkg.
module sbom_table
    import sbom_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int OFFSET_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic signed [ROW_W-1:0]        wr_row,
    input  logic signed [LEFT_W-1:0]       wr_left,
    input  logic [RIGHT_W-1:0]             wr_right,
    input  logic [OFFSET_BITS-1:0]         wr_start,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    input  probe_t                         probe,
    output logic                           hit,
    output logic [OUT_W-1:0]               offset
);

    localparam int ENTRY_W = ROW_W + LEFT_W + RIGHT_W + OFFSET_BITS;
    localparam int WIDE_W  = OFFSET_BITS + OUT_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic signed [ROW_W-1:0]  q_row;
    logic signed [LEFT_W-1:0] q_left;
    logic [RIGHT_W-1:0]       q_right;
    logic [OFFSET_BITS-1:0]   q_start;
    logic signed [LEFT_W:0]   col_ext;
    logic signed [LEFT_W:0]   right_ext;
    logic signed [LEFT_W:0]   diff;
    logic [PROD_W-1:0]        prod;
    logic [WIDE_W-1:0]        sum_wide;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_row, wr_left, wr_right, wr_start};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign {q_row, q_left, q_right, q_start} = rd_data_reg;

    assign col_ext   = {probe.col[LEFT_W-1], probe.col};
    assign right_ext = {2'b00, q_right};
    assign diff      = col_ext - {q_left[LEFT_W-1], q_left};

    assign hit = ({q_row[ROW_W-1], q_row} == probe.target_row)
              && (probe.col >= q_left)
              && (col_ext < right_ext);

    // diff is non-negative and fits DIFF_W bits whenever the span holds col
    assign prod     = diff[DIFF_W-1:0] * probe.cpc;
    assign sum_wide = {{OUT_W{1'b0}}, q_start}
                    + {{(WIDE_W-PROD_W){1'b0}}, prod};
    assign offset   = sum_wide[OUT_W-1:0];

endmodule

@@ rtl/sparse_band_offset_mapper_unit.sv @@
// Top level of the sparse band offset mapper: handshakes, sequencer, running
// total and scan pointers. Uses sbom_pkg and instantiates sbom_table.
//
//  channel  | direction | beat contents
//  ---------+-----------+----------------------------------------------------
//  s_       | in        | opcode, bound_row, bound_left, bound_right
//  m_       | out       | status, offset_prev_row/same_row/next_row, total_cells
//  cfg_     | in        | cells_per_column (4 bits)
//
// Load, clear and the unused opcode pass from the exec state to the done state,
// which loads the result register once m_ is free. A map adds a seek state per
// row and a check per table entry read from that row's pointer onward (single table read port).
// Reset clears count, total, pointers and the output valid; cells_per_column
// returns to 3. A new beat is accepted while a finished result waits on m_;
// the sequencer holds in its done state only when a second result is ready.
module sparse_band_offset_mapper_unit
    import sbom_pkg::*;
#(
    parameter int MAX_OUTER_BOUNDS = 1024,
    parameter int OFFSET_BITS      = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic signed [ROW_W-1:0]   s_bound_row,
    input  logic signed [LEFT_W-1:0]  s_bound_left,
    input  logic [RIGHT_W-1:0]        s_bound_right,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [OUT_W-1:0]          m_offset_prev_row,
    output logic [OUT_W-1:0]          m_offset_same_row,
    output logic [OUT_W-1:0]          m_offset_next_row,
    output logic [OUT_W-1:0]          m_total_cells,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CPC_W-1:0]          cfg_data
);

    localparam int AW     = $clog2(MAX_OUTER_BOUNDS);
    localparam int CW     = $clog2(MAX_OUTER_BOUNDS + 1);
    localparam int SPAN_W = LEFT_W + 1 + CPC_W + 1;
    localparam int SUM_W  = ((OFFSET_BITS > SPAN_W) ? OFFSET_BITS : SPAN_W) + 2;
    localparam int WIDE_W = OFFSET_BITS + OUT_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_OUTER_BOUNDS);
    localparam logic [1:0]    K_LAST    = 2'd2;

    state_t                   state_reg, state_next;
    opcode_t                  op_reg, op_next;
    logic signed [ROW_W-1:0]  row_reg, row_next;
    logic signed [LEFT_W-1:0] left_reg, left_next;
    logic [RIGHT_W-1:0]       right_reg, right_next;
    logic [CPC_W-1:0]         cpc_reg, cpc_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [OFFSET_BITS-1:0]   total_reg, total_next;
    logic [CW-1:0]            ptr_reg [3];
    logic [CW-1:0]            ptr_next [3];
    logic [1:0]               k_reg, k_next;
    logic [CW-1:0]            scan_reg, scan_next;
    status_t                  res_status_reg, res_status_next;
    logic [OUT_W-1:0]         res_off_reg [3];
    logic [OUT_W-1:0]         res_off_next [3];
    logic [OUT_W-1:0]         res_total_reg, res_total_next;
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_status_reg, m_status_next;
    logic [OUT_W-1:0]         m_off_reg [3];
    logic [OUT_W-1:0]         m_off_next [3];
    logic [OUT_W-1:0]         m_total_reg, m_total_next;

    logic                     out_free;
    logic [CW-1:0]            cur_ptr;
    logic                     cur_in_table;
    logic [CW-1:0]            scan_plus;
    logic                     scan_more;

    logic signed [LEFT_W:0]   span_diff;
    logic signed [SPAN_W-1:0] span;
    logic signed [SUM_W-1:0]  load_sum;
    logic                     load_ovf;
    logic [WIDE_W-1:0]        total_wide;
    logic [WIDE_W-1:0]        sum_wide;

    logic                     tbl_wr_en;
    logic                     tbl_rd_en;
    logic [AW-1:0]            tbl_rd_addr;
    probe_t                   probe;
    logic signed [ROW_W:0]    row_ext;
    logic                     tbl_hit;
    logic [OUT_W-1:0]         tbl_offset;

    sbom_table #(
        .DEPTH       (MAX_OUTER_BOUNDS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_row   (row_reg),
        .wr_left  (left_reg),
        .wr_right (right_reg),
        .wr_start (total_reg),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .probe    (probe),
        .hit      (tbl_hit),
        .offset   (tbl_offset)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign cur_ptr      = ptr_reg[k_reg];
    assign cur_in_table = (cur_ptr < count_reg);
    assign scan_plus    = scan_reg + 1'b1;
    assign scan_more    = (scan_plus < count_reg);

    // Probe row for the pointer being scanned: row-1, row, row+1
    assign row_ext = {row_reg[ROW_W-1], row_reg};
    always_comb begin
        case (k_reg)
            2'd0:    probe.target_row = row_ext - 1'b1;
            2'd1:    probe.target_row = row_ext;
            default: probe.target_row = row_ext + 1'b1;
        endcase
        probe.col = left_reg;
        probe.cpc = cpc_reg;
    end

    // Load arithmetic: new total = total + (right - left) * cells_per_column
    assign span_diff = $signed({2'b00, right_reg}) - $signed({left_reg[LEFT_W-1], left_reg});
    assign span      = span_diff * $signed({1'b0, cpc_reg});
    assign load_sum  = $signed({{(SUM_W-OFFSET_BITS){1'b0}}, total_reg})
                     + $signed({{(SUM_W-SPAN_W){span[SPAN_W-1]}}, span});
    assign load_ovf  = load_sum[SUM_W-1] || (load_sum[SUM_W-1:OFFSET_BITS] != '0);

    assign total_wide = {{OUT_W{1'b0}}, total_reg};
    assign sum_wide   = {{OUT_W{1'b0}}, load_sum[OFFSET_BITS-1:0]};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = (op_reg == OP_MAP) ? S_SEEK : S_DONE;
            end
            S_SEEK: begin
                if (cur_in_table) begin
                    state_next = S_CHECK;
                end else if (k_reg == K_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_CHECK: begin
                if (tbl_hit || !scan_more) begin
                    state_next = (k_reg == K_LAST) ? S_DONE : S_SEEK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        op_next         = op_reg;
        row_next        = row_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        cpc_next        = cfg_valid ? cfg_data : cpc_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        ptr_next        = ptr_reg;
        k_next          = k_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_total_next  = res_total_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_off_next      = m_off_reg;
        m_total_next    = m_total_reg;
        tbl_wr_en       = 1'b0;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = cur_ptr[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = opcode_t'(s_opcode);
                    row_next   = s_bound_row;
                    left_next  = s_bound_left;
                    right_next = s_bound_right;
                end
            end
            S_EXEC: begin
                res_status_next = STAT_OK;
                res_off_next    = '{default: '0};
                res_total_next  = total_wide[OUT_W-1:0];
                k_next          = 2'd0;
                case (op_reg)
                    OP_LOAD: begin
                        if (count_reg == MAX_COUNT) begin
                            res_status_next = STAT_FULL;
                        end else if (load_ovf) begin
                            res_status_next = STAT_OVERFLOW;
                        end else begin
                            tbl_wr_en      = 1'b1;
                            count_next     = count_reg + 1'b1;
                            total_next     = load_sum[OFFSET_BITS-1:0];
                            res_total_next = sum_wide[OUT_W-1:0];
                        end
                    end
                    OP_CLEAR: begin
                        count_next     = '0;
                        total_next     = '0;
                        ptr_next       = '{default: '0};
                        res_total_next = '0;
                    end
                    default: ;
                endcase
            end
            S_SEEK: begin
                if (cur_in_table) begin
                    tbl_rd_en = 1'b1;
                    scan_next = cur_ptr;
                end else begin
                    res_status_next = STAT_NO_MATCH;
                    k_next          = k_reg + 1'b1;
                end
            end
            S_CHECK: begin
                if (tbl_hit) begin
                    res_off_next[k_reg] = tbl_offset;
                    ptr_next[k_reg]     = scan_reg;
                    k_next              = k_reg + 1'b1;
                end else if (scan_more) begin
                    // advance one entry; read of the next one overlaps the test
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = scan_plus[AW-1:0];
                    scan_next   = scan_plus;
                end else begin
                    // miss: leave this row's pointer where it was
                    res_status_next = STAT_NO_MATCH;
                    k_next          = k_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_off_next    = res_off_reg;
                    m_total_next  = res_total_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cpc_reg     <= CPC_RESET;
            count_reg   <= '0;
            total_reg   <= '0;
            ptr_reg     <= '{default: '0};
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cpc_reg     <= cpc_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            ptr_reg     <= ptr_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        row_reg        <= row_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_total_reg  <= res_total_next;
        m_status_reg   <= m_status_next;
        m_off_reg      <= m_off_next;
        m_total_reg    <= m_total_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_offset_prev_row = m_off_reg[0];
    assign m_offset_same_row = m_off_reg[1];
    assign m_offset_next_row = m_off_reg[2];
    assign m_total_cells     = m_total_reg;

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for sparse_band_offset_mapper_unit: directed vectors, then banded
// load/map sequences and random noise, checked against an in-bench offset predictor.
// Depends on rtl/sbom_pkg.sv and rtl/sparse_band_offset_mapper_unit.sv.
`timescale 1ns / 100ps

module testbench;
    import sbom_pkg::*;

    localparam int MAXB        = 1024;
    localparam int OFF_BITS    = 32;
    localparam longint OFF_LIMIT = (longint'(1) << OFF_BITS) - 1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_BEATS = 560;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [ROW_W-1:0]  row;
        logic signed [LEFT_W-1:0] left;
        logic [RIGHT_W-1:0]       right;
    } beat_t;

    typedef struct packed {
        status_t           status;
        logic [OUT_W-1:0]  prev_off;
        logic [OUT_W-1:0]  same_off;
        logic [OUT_W-1:0]  next_off;
        logic [OUT_W-1:0]  total;
    } answer_t;

    typedef struct packed {
        beat_t   beat;
        bit      fixed;
        answer_t want;
    } vector_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = 2'd0;
    logic signed [ROW_W-1:0] s_bound_row = '0;
    logic signed [LEFT_W-1:0] s_bound_left = '0;
    logic [RIGHT_W-1:0] s_bound_right = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic [OUT_W-1:0] m_offset_prev_row;
    logic [OUT_W-1:0] m_offset_same_row;
    logic [OUT_W-1:0] m_offset_next_row;
    logic [OUT_W-1:0] m_total_cells;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CPC_W-1:0] cfg_data = '0;

    sparse_band_offset_mapper_unit #(
        .MAX_OUTER_BOUNDS(MAXB),
        .OFFSET_BITS(OFF_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_bound_row(s_bound_row),
        .s_bound_left(s_bound_left),
        .s_bound_right(s_bound_right),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_offset_prev_row(m_offset_prev_row),
        .m_offset_same_row(m_offset_same_row),
        .m_offset_next_row(m_offset_next_row),
        .m_total_cells(m_total_cells),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // Predictor state: bound table, running total, scan pointers, cells per column.
    longint bound_row_mem   [MAXB];
    longint bound_left_mem  [MAXB];
    longint bound_right_mem [MAXB];
    longint bound_start_mem [MAXB];
    int     bound_count = 0;
    longint cells_total = 0;
    int     ptr_prev = 0;
    int     ptr_same = 0;
    int     ptr_next = 0;
    longint cpc_val = longint'(CPC_RESET);

    answer_t pending_answers[$];
    vector_t directed_q[$];
    answer_t head;

    int beats_issued = 0;
    int answers_checked = 0;
    int mismatch_count = 0;
    int load_count = 0;
    int map_count = 0;
    int full_answers = 0;
    int overflow_answers = 0;
    int miss_answers = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;
    int hold_requests = 0;
    bit sender_steady = 1'b0;

    // Walk forward from ptr to the first bound on row target whose span holds col.
    function automatic bit seek_offset(inout int ptr, input longint target, input longint col,
                                       output logic [OUT_W-1:0] off);
        int p;
        p = ptr;
        off = '0;
        while (p < bound_count) begin
            if (bound_row_mem[p] == target && col >= bound_left_mem[p] &&
                col < bound_right_mem[p]) begin
                off = OUT_W'(bound_start_mem[p] + (col - bound_left_mem[p]) * cpc_val);
                ptr = p;
                return 1'b1;
            end
            p++;
        end
        return 1'b0;
    endfunction

    function automatic answer_t compute_answer(beat_t b);
        answer_t a;
        longint row_v, left_v, right_v, sum;
        bit hit_p, hit_s, hit_n;
        a.status   = STAT_OK;
        a.prev_off = '0;
        a.same_off = '0;
        a.next_off = '0;
        row_v   = longint'($signed(b.row));
        left_v  = longint'($signed(b.left));
        right_v = longint'(b.right);
        case (b.opcode)
            OP_LOAD: begin
                load_count++;
                if (bound_count >= MAXB) begin
                    a.status = STAT_FULL;
                end else begin
                    sum = cells_total + (right_v - left_v) * cpc_val;
                    if (sum < 0 || sum > OFF_LIMIT) begin
                        a.status = STAT_OVERFLOW;
                    end else begin
                        bound_row_mem[bound_count]   = row_v;
                        bound_left_mem[bound_count]  = left_v;
                        bound_right_mem[bound_count] = right_v;
                        bound_start_mem[bound_count] = cells_total;
                        bound_count++;
                        cells_total = sum;
                    end
                end
                a.total = cells_total[OUT_W-1:0];
            end
            OP_MAP: begin
                map_count++;
                hit_p = seek_offset(ptr_prev, row_v - 1, left_v, a.prev_off);
                hit_s = seek_offset(ptr_same, row_v, left_v, a.same_off);
                hit_n = seek_offset(ptr_next, row_v + 1, left_v, a.next_off);
                if (!(hit_p && hit_s && hit_n)) a.status = STAT_NO_MATCH;
                a.total = cells_total[OUT_W-1:0];
            end
            OP_CLEAR: begin
                bound_count = 0;
                cells_total = 0;
                ptr_prev = 0;
                ptr_same = 0;
                ptr_next = 0;
                a.total = '0;
            end
            default: begin
                a.total = cells_total[OUT_W-1:0];
            end
        endcase
        case (a.status)
            STAT_FULL:     full_answers++;
            STAT_OVERFLOW: overflow_answers++;
            STAT_NO_MATCH: miss_answers++;
            default: ;
        endcase
        return a;
    endfunction

    function automatic beat_t make_beat(logic [1:0] op, int row, int left, int right);
        beat_t b;
        b.opcode = op;
        b.row    = ROW_W'(row);
        b.left   = LEFT_W'(left);
        b.right  = RIGHT_W'(right);
        return b;
    endfunction

    function automatic beat_t noise_beat(bit no_clear);
        int pick, row, left, right;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_LOAD;
        else if (pick < 80) op = OP_MAP;
        else if (pick < 90) op = OP_UNUSED;
        else if (no_clear) op = OP_MAP;
        else op = OP_CLEAR;
        row   = $urandom_range(0, 1) ? int'($urandom_range(0, 9)) - 1
                                     : int'($urandom_range(0, 65536)) - 1;
        left  = $urandom_range(0, 1) ? int'($urandom_range(0, 31)) - 1
                                     : int'($urandom_range(0, 65537)) - 1;
        right = $urandom_range(0, 1) ? int'($urandom_range(0, 32))
                                     : int'($urandom_range(0, 65537));
        return make_beat(op, row, left, right);
    endfunction

    task automatic add_vec(logic [1:0] op, int row, int left, int right, bit fixed,
                           status_t st, longint total);
        vector_t v;
        v.beat = make_beat(op, row, left, right);
        v.fixed = fixed;
        v.want.status = st;
        v.want.prev_off = '0;
        v.want.same_off = '0;
        v.want.next_off = '0;
        v.want.total = OUT_W'(total);
        directed_q.push_back(v);
    endtask

    task automatic sender_gap();
        int g, pick;
        pick = $urandom_range(0, 99);
        if (sender_steady || pick < 55) g = 0;
        else if (pick < 88) g = $urandom_range(1, 3);
        else if (pick < 97) g = $urandom_range(4, 12);
        else g = $urandom_range(30, 120);
        if (g > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    // Offer one beat, hold it until accepted, then queue its fixed or predicted answer.
    task automatic issue(beat_t b, bit fixed = 1'b0, answer_t want = '0);
        answer_t pred;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_opcode      <= b.opcode;
        s_bound_row   <= b.row;
        s_bound_left  <= b.left;
        s_bound_right <= b.right;
        do @(posedge aclk); while (!s_ready);
        pred = compute_answer(b);
        pending_answers.push_back(fixed ? want : pred);
        beats_issued++;
        sender_gap();
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cpc(logic [CPC_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cpc_val = longint'(v);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Clear, load a drifting band of bounds row by row, then map along it in order.
    task automatic run_band(int nrows, bit loose, int spill_loads, int row_step_max);
        int lo[], hi[];
        int drift, span_max, c0, r0, pick, i, k, nq, col, cut, hole;
        lo = new[nrows];
        hi = new[nrows];
        drift = 0;
        span_max = 0;
        for (i = 0; i < nrows; i++) begin
            lo[i] = drift;
            hi[i] = drift + $urandom_range(2, 24);
            if (hi[i] > span_max) span_max = hi[i];
            drift += $urandom_range(0, 3);
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) c0 = -1;
        else if (pick < 4) c0 = 65537 - span_max;
        else c0 = int'($urandom_range(0, 65537 - span_max)) - 1;
        pick = $urandom_range(0, 9);
        if (pick < 2) r0 = -1;
        else if (pick < 4) r0 = 65536 - nrows;
        else r0 = int'($urandom_range(0, 65536 - nrows)) - 1;
        for (i = 0; i < nrows; i++) begin
            lo[i] += c0;
            hi[i] += c0;
        end

        issue(make_beat(OP_CLEAR, r0, c0, 0));
        for (i = 0; i < nrows; i++) begin
            if (loose && $urandom_range(0, 99) < 5) issue(noise_beat(1'b1));
            if (loose && hi[i] - lo[i] >= 6 && $urandom_range(0, 3) == 0) begin
                // split the row into two bounds, sometimes with a hole between
                cut  = lo[i] + $urandom_range(2, hi[i] - lo[i] - 3);
                hole = $urandom_range(0, 2);
                issue(make_beat(OP_LOAD, r0 + i, lo[i], cut));
                issue(make_beat(OP_LOAD, r0 + i, cut + hole, hi[i]));
            end else begin
                issue(make_beat(OP_LOAD, r0 + i, lo[i], hi[i]));
            end
        end
        repeat (spill_loads) issue(make_beat(OP_LOAD, r0, lo[0], hi[0]));

        i = 0;
        while (i < nrows) begin
            nq  = $urandom_range(1, 3);
            col = lo[i] + int'($urandom_range(0, 4)) - 1;
            for (k = 0; k < nq; k++) begin
                if (col < -1) col = -1;
                if (col > 65536) col = 65536;
                issue(make_beat(OP_MAP, r0 + i, col, int'($urandom_range(0, 65537))));
                col += $urandom_range(0, (hi[i] - lo[i]) / 2 + 1);
            end
            if (loose && $urandom_range(0, 99) < 4) issue(noise_beat(1'b1));
            i += $urandom_range(1, row_step_max);
        end
    endtask

    // Result side: random back-pressure, plus one long hold on request.
    initial begin : result_sink
        int hold_left, run_left, served, pick;
        hold_left = 0;
        run_left = 0;
        served = 0;
        forever begin
            @(negedge aclk);
            if (served != hold_requests) begin
                served = hold_requests;
                hold_left = LONG_HOLD;
                run_left = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) run_left = $urandom_range(0, 4);
                else if (pick < 68) run_left = $urandom_range(50, 300);
                else if (pick < 90) hold_left = $urandom_range(0, 2);
                else if (pick < 98) hold_left = $urandom_range(3, 15);
                else hold_left = $urandom_range(40, 150);
                m_ready <= (pick < 68);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result beat, status %0d total %0h",
                             $realtime, m_status, m_total_cells);
            end else begin
                head = pending_answers.pop_front();
                answers_checked++;
                if (m_status !== head.status || m_offset_prev_row !== head.prev_off ||
                    m_offset_same_row !== head.same_off ||
                    m_offset_next_row !== head.next_off || m_total_cells !== head.total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result %0d exp/got status %0d/%0d prev %0h/%0h same %0h/%0h next %0h/%0h total %0h/%0h",
                                 $realtime, answers_checked, head.status, m_status,
                                 head.prev_off, m_offset_prev_row,
                                 head.same_off, m_offset_same_row,
                                 head.next_off, m_offset_next_row,
                                 head.total, m_total_cells);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, pending_answers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int phase, pick;
        logic [CPC_W-1:0] cpc_plan [6];
        cpc_plan = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd5, 4'd3};

        // cells per column is 3 out of reset for the whole directed part
        add_vec(OP_UNUSED, -1, -1, 65537, 1'b1, STAT_OK, 0);
        add_vec(OP_MAP, 0, 0, 0, 1'b1, STAT_NO_MATCH, 0);
        add_vec(OP_LOAD, 0, 10, 0, 1'b1, STAT_OVERFLOW, 0);
        add_vec(OP_LOAD, -1, -1, 65537, 1'b1, STAT_OK, 196614);
        add_vec(OP_LOAD, 0, 0, 65536, 1'b1, STAT_OK, 393222);
        add_vec(OP_LOAD, 1, 65536, 65537, 1'b1, STAT_OK, 393225);
        add_vec(OP_MAP, 0, 0, 131071, 1'b0, STAT_OK, 0);
        add_vec(OP_MAP, 0, 65536, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_LOAD, 65535, 65536, 65537, 1'b0, STAT_OK, 0);
        add_vec(OP_LOAD, 65534, 65536, 65537, 1'b0, STAT_OK, 0);
        add_vec(OP_MAP, 65535, 65536, 65537, 1'b0, STAT_OK, 0);
        add_vec(OP_LOAD, 3, 65536, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_MAP, -1, -1, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_CLEAR, 65535, 65536, 65537, 1'b1, STAT_OK, 0);
        add_vec(OP_MAP, 0, 0, 0, 1'b1, STAT_NO_MATCH, 0);
        add_vec(OP_LOAD, 5, 0, 0, 1'b1, STAT_OK, 0);
        add_vec(OP_LOAD, 5, 1, 0, 1'b1, STAT_OVERFLOW, 0);
        add_vec(OP_LOAD, 4, 0, 4, 1'b1, STAT_OK, 12);
        add_vec(OP_LOAD, 6, 0, 4, 1'b1, STAT_OK, 24);
        add_vec(OP_LOAD, 5, 0, 4, 1'b1, STAT_OK, 36);
        add_vec(OP_MAP, 5, 2, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_MAP, 5, 0, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_MAP, 5, 4, 0, 1'b0, STAT_OK, 0);
        add_vec(OP_UNUSED, 0, 0, 0, 1'b1, STAT_OK, 36);
        add_vec(OP_CLEAR, 0, 0, 0, 1'b1, STAT_OK, 0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_q[i])
            issue(directed_q[i].beat, directed_q[i].fixed, directed_q[i].want);

        phase = 0;
        while (beats_issued < RANDOM_BEATS) begin
            wait_idle();
            write_cpc(phase < 6 ? cpc_plan[phase] : CPC_W'($urandom_range(0, 15)));
            sender_steady = (phase % 5 == 2);
            // fill the block while the result side holds off
            if (phase == 3) hold_requests++;
            pick = $urandom_range(0, 99);
            if (phase == 3 || pick < 75)
                run_band($urandom_range(3, 14), 1'b1, 0, 1);
            else
                repeat ($urandom_range(10, 30)) issue(noise_beat(1'b0));
            phase++;
        end

        // fill the table to its limit, push loads past it, then map sparsely across it
        wait_idle();
        write_cpc(4'd15);
        sender_steady = 1'b1;
        run_band(MAXB, 1'b0, 3, 40);
        sender_steady = 1'b0;

        wait_idle();
        repeat (64) @(posedge aclk);
        if (pending_answers.size() != 0) begin
            mismatch_count += pending_answers.size();
            $display("%0d expected results never arrived", pending_answers.size());
        end
        $display("Covered %0d beats (%0d loads, %0d maps) and %0d register writes; %0d results checked.",
                 beats_issued, load_count, map_count, cfg_writes, answers_checked);
        $display("Table full %0d, offset overflow %0d, unmatched maps %0d, mismatches %0d.",
                 full_answers, overflow_answers, miss_answers, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
